// ===== rtl/ese_pkg.sv =====
// ese_pkg: shared types and constants for the exponential search engine
// word layouts of both channels, compare result struct, function codes
// no dependencies
package ese_pkg;

    localparam int KEY_W           = 32;
    localparam int IDX_W           = 10;
    localparam int CFG_W           = 11;
    // probe index reaches 2048, the first power of two above the largest size 2047
    localparam int PROBE_W         = 12;
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
    } t_out_word;

    typedef struct packed {
        logic eq;
        logic gt;
    } t_cmp_res;

endpackage

// ===== rtl/ese_ram.sv =====
// ese_ram: generic single write port, single read port memory
// read data registered, valid in the cycle after the address
// no dependencies
module ese_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/ese_cmp.sv =====
// ese_cmp: shared signed key comparator used by both search phases
// depends on ese_pkg
module ese_cmp
    import ese_pkg::*;
(
    input  logic signed [KEY_W-1:0] i_table_key,
    input  logic signed [KEY_W-1:0] i_want,
    output t_cmp_res                o_res
);

    always_comb begin
        o_res.eq = (i_table_key == i_want);
        o_res.gt = (i_table_key > i_want);
    end

endmodule

// ===== rtl/exponential_search_engine.sv =====
// exponential_search_engine: top level, sequencer for the probe and bisection phases
// depends on ese_pkg, ese_ram, ese_cmp
//
// usage:
//   input channel (i_in_valid / o_in_stall, i_in_word) carries load and lookup words.
//   a load word writes one table entry in the cycle it is taken and gives no result.
//   a lookup word gives one result word on o_out_valid / i_out_stall, i_out_stall
//   holding the result in the output register.
//   table_size is written on i_cfg_valid / o_cfg_ready (always ready); the user must write
//   it only while idle, as the block itself does not enforce this.
// sequencing:
//   a lookup passes a read and a compare state per doubling probe, a setup state for the
//   bounds, a read and a compare state per bisection step, a last bound check on a miss
//   and a done state; each probe and step is one table memory read and one comparator pass.
//   o_in_stall is high from the cycle after a lookup is taken until its result sits
//   in the output register; a result may wait there while the next word is taken.
//   if the previous result is still stalled, the finished lookup waits for it.
// reset:
//   synchronous active-low; clears the sequencer, output valid and table_size.
//   table contents are not cleared and must be loaded before use.
module exponential_search_engine
    import ese_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int SIZE_MAX = (1 << CFG_W) - 1;
    localparam int SIZE_CAP = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRD,
        ST_PCMP,
        ST_SETUP,
        ST_BRD,
        ST_BCMP,
        ST_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic [CFG_W-1:0]          r_table_size;
    logic [CFG_W-1:0]          r_size, n_size;
    logic signed [KEY_W-1:0]   r_want, n_want;
    logic [PROBE_W-1:0]        r_probe, n_probe;
    logic signed [PROBE_W:0]   r_lo, n_lo;
    logic signed [PROBE_W:0]   r_hi, n_hi;
    logic [PROBE_W-1:0]        r_mid, n_mid;
    logic                      r_hit, n_hit;
    logic [IDX_W-1:0]          r_where, n_where;
    logic                      r_out_valid;
    t_out_word                 r_out_word;

    logic                      in_take;
    logic                      out_free;
    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [KEY_W-1:0]          ram_rdata;
    t_cmp_res                  cmp;
    logic signed [PROBE_W+1:0] bis_sum;
    logic [PROBE_W-1:0]        bis_mid;
    logic [PROBE_W-1:0]        probe_dbl;
    logic [PROBE_W-1:0]        size_m1;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // load words beyond the table depth are dropped
    assign ram_we = in_take && (i_in_word.func == FUNC_LOAD)
                    && (32'(i_in_word.entry_index) < 32'(TABLE_DEPTH));

    assign bis_sum   = (PROBE_W+2)'(r_lo) + (PROBE_W+2)'(r_hi);
    assign bis_mid   = bis_sum[PROBE_W:1];
    assign probe_dbl = {r_probe[PROBE_W-2:0], 1'b0};
    assign size_m1   = PROBE_W'(r_size) - PROBE_W'(1);

    assign ram_re    = (r_state == ST_PRD) || (r_state == ST_BRD);
    assign ram_raddr = (r_state == ST_PRD) ? AW'(r_probe) : AW'(bis_mid);

    ese_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in_word.entry_index)),
        .i_wdata (i_in_word.key),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ese_cmp u_cmp (
        .i_table_key (ram_rdata),
        .i_want      (r_want),
        .o_res       (cmp)
    );

    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_want  = r_want;
        n_probe = r_probe;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_hit   = r_hit;
        n_where = r_where;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take && (i_in_word.func == FUNC_LOOKUP)) begin
                    n_want  = i_in_word.key;
                    n_probe = PROBE_W'(1);
                    n_hit   = 1'b0;
                    n_where = '0;
                    if (32'(r_table_size) > SIZE_CAP) begin
                        n_size = CFG_W'(SIZE_CAP);
                    end else begin
                        n_size = r_table_size;
                    end
                    if (n_size == '0) begin
                        n_state = ST_DONE;
                    end else if (n_size > CFG_W'(1)) begin
                        n_state = ST_PRD;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_PRD: begin
                n_state = ST_PCMP;
            end
            ST_PCMP: begin
                // double while the probed key is not above the sought key, up to the size
                if (!cmp.gt) begin
                    n_probe = probe_dbl;
                    if (probe_dbl < PROBE_W'(r_size)) begin
                        n_state = ST_PRD;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_lo = (PROBE_W+1)'({1'b0, r_probe} >> 1);
                if (r_probe < size_m1) begin
                    n_hi = (PROBE_W+1)'(r_probe);
                end else begin
                    n_hi = (PROBE_W+1)'(size_m1);
                end
                n_state = ST_BRD;
            end
            ST_BRD: begin
                if (r_lo <= r_hi) begin
                    n_mid   = bis_mid;
                    n_state = ST_BCMP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_BCMP: begin
                if (cmp.eq) begin
                    n_hit   = 1'b1;
                    n_where = IDX_W'(r_mid);
                    n_state = ST_DONE;
                end else begin
                    if (cmp.gt) begin
                        n_hi = (PROBE_W+1)'(r_mid) - (PROBE_W+1)'(1);
                    end else begin
                        n_lo = (PROBE_W+1)'(r_mid) + (PROBE_W+1)'(1);
                    end
                    n_state = ST_BRD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_table_size <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_want  <= n_want;
        r_probe <= n_probe;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_hit   <= n_hit;
        r_where <= n_where;
        if ((r_state == ST_DONE) && out_free) begin
            r_out_word.found       <= r_hit;
            r_out_word.found_index <= r_where;
        end
    end

endmodule

// ===== verif/exponential_search_engine_tb.sv =====
// exponential_search_engine_tb: self-checking bench for the exponential search engine
// drives load and lookup words, predicts every lookup and compares each result word
// depends on ese_pkg and exponential_search_engine
module exponential_search_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ese_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // ample room after the longest lookup for the sequencer to go idle
    localparam int SETTLE      = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int KEY_MIN     = 32'sh8000_0000;
    localparam int KEY_MAX     = 32'sh7fff_ffff;
    localparam int N_PHASES    = 9;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        int        key;
        t_out_word res;
    } t_awaited;

    class search_checker;
        int          key_table[TABLE_DEPTH_DEF];
        int unsigned table_size;
        t_awaited    awaited[$];
        int          errors;

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function t_out_word predict_lookup(int want);
            int unsigned span;
            int unsigned probe;
            int          lo;
            int          hi;
            int          mid;
            t_out_word   r;
            r = '0;
            span = (table_size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : table_size;
            if (span == 0) return r;
            probe = 1;
            while (probe < span && key_table[probe] <= want) probe = probe * 2;
            lo = probe / 2;
            hi = (probe < span - 1) ? probe : span - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (key_table[mid] == want) begin
                    r.found       = 1'b1;
                    r.found_index = mid[IDX_W-1:0];
                    return r;
                end
                if (want > key_table[mid]) lo = mid + 1;
                else hi = mid - 1;
            end
            return r;
        endfunction

        function void note_word(t_in_word w);
            t_awaited a;
            if (w.func == FUNC_LOAD) begin
                key_table[w.entry_index] = w.key;
            end else begin
                a.key = w.key;
                a.res = predict_lookup(w.key);
                awaited.push_back(a);
            end
        endfunction

        function void check_result(t_out_word got);
            t_awaited a;
            if (awaited.size() == 0) begin
                flag($sformatf("result with nothing pending: found=%0b index=%0d",
                               got.found, got.found_index));
                return;
            end
            a = awaited.pop_front();
            if (got.found !== a.res.found)
                flag($sformatf("key %0d found: expected %0b got %0b",
                               a.key, a.res.found, got.found));
            if (got.found_index !== a.res.found_index)
                flag($sformatf("key %0d found_index: expected %0d got %0d",
                               a.key, a.res.found_index, got.found_index));
        endfunction

        function void check_drained();
            if (awaited.size() != 0)
                flag($sformatf("%0d lookup results never arrived", awaited.size()));
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_word         in_word   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_word        out_word;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    search_checker board;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    // large sizes first on the fully sorted table, then small reloaded prefixes, then a last full-size phase
    int         phase_size[N_PHASES]    = '{1024, 2047, 300, 600, 37, 1, 2, 5, 1024};
    int         phase_lookups[N_PHASES] = '{25, 25, 20, 20, 20, 10, 10, 10, 25};
    bit         phase_reload[N_PHASES]  = '{0, 0, 0, 0, 1, 1, 1, 1, 0};
    t_idle_mode phase_mode[N_PHASES]    = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                            IDLE_BOTH, IDLE_NONE, IDLE_RECEIVER,
                                            IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};

    exponential_search_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("exponential_search_engine_tb failed");
            $finish;
        end
    end

    // receiver side: a long hold-off when asked, otherwise random stalls
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // outputs are stable mid-cycle, so the word taken at the next edge is read here
    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_word);
    end

    function void apply_mode(t_idle_mode m);
        case (m)
            IDLE_NONE: begin
                idle_pct = 0; stall_pct = 0;
            end
            IDLE_SENDER: begin
                idle_pct = 51; stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                idle_pct = 0; stall_pct = 51;
            end
            default: begin
                idle_pct = 7; stall_pct = 7;
            end
        endcase
    endfunction

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        board.note_word(w);
    endtask

    task automatic send_load(int unsigned idx, int key);
        t_in_word w;
        w.func        = FUNC_LOAD;
        w.entry_index = idx[IDX_W-1:0];
        w.key         = key;
        send_word(w);
    endtask

    task automatic send_lookup(int key);
        t_in_word w;
        w.func        = FUNC_LOOKUP;
        w.entry_index = IDX_W'($urandom);  // ignored on a lookup, so noise
        w.key         = key;
        send_word(w);
    endtask

    // wait for every pending result, then let a trailing load finish
    task automatic quiesce();
        in_valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        board.table_size = v;
        cfg_valid <= 1'b0;
    endtask

    // ascending keys spread over the whole range, with the odd duplicate
    task automatic load_sorted(int unsigned count);
        longint      acc;
        int unsigned step;
        step = 32'hffff_ffff / (count + 1);
        acc  = longint'(KEY_MIN) + $urandom_range(step);
        for (int unsigned i = 0; i < count; i++) begin
            if (i != 0 && $urandom_range(15) != 0) acc += $urandom_range(step);
            send_load(i, int'(acc));
        end
    endtask

    function automatic int pick_key(int unsigned span);
        int unsigned at;
        int          k;
        at = $urandom_range(span - 1);
        case ($urandom_range(9))
            6: k = board.key_table[at] + (($urandom_range(1) == 0) ? 1 : -1);
            7, 8: k = $urandom;
            9: begin
                case ($urandom_range(2))
                    0: k = KEY_MIN;
                    1: k = KEY_MAX;
                    default: k = 0;
                endcase
            end
            default: k = board.key_table[at];
        endcase
        return k;
    endfunction

    initial begin
        int unsigned span;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        apply_mode(IDLE_NONE);
        write_size(0);
        send_lookup(0);
        send_lookup(KEY_MIN);
        send_lookup(KEY_MAX);

        // small hand-built table: extremes, zero key twice, gaps between keys
        quiesce();
        write_size(8);
        send_load(0, KEY_MIN);
        send_load(1, -5);
        send_load(2, 0);
        send_load(3, 0);
        send_load(4, 7);
        send_load(5, 100);
        send_load(6, 1000);
        send_load(7, KEY_MAX);
        send_lookup(KEY_MIN);
        send_lookup(-5);
        send_lookup(0);
        send_lookup(7);
        send_lookup(1000);
        send_lookup(KEY_MAX);
        send_lookup(1);
        send_lookup(-6);
        send_lookup(KEY_MAX - 1);

        // every entry written once, so no later lookup can touch a stale slot
        load_sorted(TABLE_DEPTH_DEF);

        for (int p = 0; p < N_PHASES; p++) begin
            quiesce();
            apply_mode(phase_mode[p]);
            write_size(CFG_W'(phase_size[p]));
            span = (phase_size[p] > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : phase_size[p];
            if (phase_reload[p]) load_sorted(span);
            if (p == 4) hold_left = HOLD_CYCLES;
            for (int n = 0; n < phase_lookups[p]; n++) begin
                // last phase mixes in stray loads, leaving the table unsorted
                if (p == N_PHASES - 1 && $urandom_range(3) == 0)
                    send_load($urandom_range(TABLE_DEPTH_DEF - 1), $urandom);
                send_lookup(pick_key(span));
            end
        end

        quiesce();
        board.check_drained();
        if (board.errors == 0) begin
            $display("exponential_search_engine_tb passed");
        end else begin
            $display("exponential_search_engine_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ese_pkg.sv
rtl/ese_ram.sv
rtl/ese_cmp.sv
rtl/exponential_search_engine.sv
verif/exponential_search_engine_tb.sv
